/* hw/rtl/mexp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, defaults and register indexes for the modular exponentiation
// block
// ----------------------------------------------------------------------------
package mexp_pkg;

    // default widths of modulus and exponent
    localparam int MOD_WIDTH_DEF = 32;
    localparam int EXP_WIDTH_DEF = 64;

    // base field width, fixed by the request format
    localparam int BASE_WIDTH = 64;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd1;

    // bit counter of the serial multiplier, must hold BASE_WIDTH
    localparam int CNT_WIDTH = $clog2(BASE_WIDTH + 1);

endpackage : mexp_pkg
`default_nettype wire

/* hw/rtl/modular_exponentiation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// right-to-left binary square and multiply, base^exponent mod modulus, on a
// bit-serial modular multiplier
// ----------------------------------------------------------------------------
// from request accept to power valid the block reduces the base, then for each
//   exponent bit up to the highest set one runs a multiply if the bit is set and
//   a square, then waits in S_DONE for the output register to free up
// a zero exponent or zero modulus skips the multiplier
// throughput: one request at a time; the serial multiplier retires one
//   operand bit per cycle and is shared by base reduction, multiply and square
// reset: modulus = 1, exponent = 0, no result pending
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  wire  logic                                    clk,
    input  wire  logic                                    rst_n,

    // configuration write port
    input  wire  logic                                    cfg_we,
    input  wire  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire  logic [(MOD_WIDTH > EXP_WIDTH ? MOD_WIDTH : EXP_WIDTH)-1:0] cfg_data,

    // request channel
    input  wire  logic                                    in_valid,
    output logic                                          in_ready,
    input  wire  logic [mexp_pkg::BASE_WIDTH-1:0]         base,

    // result channel
    output logic                                          out_valid,
    input  wire  logic                                    out_ready,
    output logic [MOD_WIDTH-1:0]                          power
);

    import mexp_pkg::*;

    // working width of the multiplier step: 2r + b stays below 3*modulus
    localparam int TW = MOD_WIDTH + 2;
    localparam int PAD_WIDTH = BASE_WIDTH - MOD_WIDTH;

    // controller states
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [STATE_W-1:0] S_RED  = 3'd1;  // base mod modulus
    localparam logic [STATE_W-1:0] S_STEP = 3'd2;  // pick next exponent bit
    localparam logic [STATE_W-1:0] S_MUL  = 3'd3;  // acc = acc * sq mod m
    localparam logic [STATE_W-1:0] S_SQR  = 3'd4;  // sq = sq * sq mod m
    localparam logic [STATE_W-1:0] S_DONE = 3'd5;  // hand acc to the output

    // configuration registers
    logic [MOD_WIDTH-1:0]  modulus_reg, modulus_next;
    logic [EXP_WIDTH-1:0]  exponent_reg, exponent_next;

    // control
    logic [STATE_W-1:0]    state_reg, state_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [BASE_WIDTH-1:0] mul_a_reg, mul_a_next;   // multiplier bits, msb first
    logic [MOD_WIDTH-1:0]  mul_b_reg, mul_b_next;   // addend, always reduced
    logic [MOD_WIDTH-1:0]  mul_r_reg, mul_r_next;   // partial remainder
    logic [MOD_WIDTH-1:0]  acc_reg, acc_next;       // running result
    logic [MOD_WIDTH-1:0]  sq_reg, sq_next;         // running square
    logic [EXP_WIDTH-1:0]  exp_sh_reg, exp_sh_next; // remaining exponent bits
    logic [MOD_WIDTH-1:0]  power_reg, power_next;

    // serial multiplier step
    logic [TW-1:0]         step_t;
    logic [TW:0]           step_d1;
    logic [TW:0]           step_d2;
    logic [MOD_WIDTH-1:0]  step_r;
    logic                  mul_last;
    logic                  out_free;

    // one operand bit per cycle: r = 2r + bit*b, then bring back below m
    always_comb
    begin
        step_t  = {1'b0, mul_r_reg, 1'b0}
                + {2'b00, (mul_a_reg[BASE_WIDTH-1] ? mul_b_reg : {MOD_WIDTH{1'b0}})};
        step_d1 = {1'b0, step_t} - {3'b000, modulus_reg};
        step_d2 = {1'b0, step_t} - {2'b00, modulus_reg, 1'b0};
        if (!step_d2[TW])
        begin
            step_r = step_d2[MOD_WIDTH-1:0];
        end
        else if (!step_d1[TW])
        begin
            step_r = step_d1[MOD_WIDTH-1:0];
        end
        else
        begin
            step_r = step_t[MOD_WIDTH-1:0];
        end
    end

    assign mul_last = (cnt_reg == CNT_WIDTH'(1));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_r_next     = mul_r_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_sh_next    = exp_sh_reg;
        power_next     = power_reg;

        // register writes, ignored beyond the register list
        if (cfg_we)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                modulus_next = cfg_data[MOD_WIDTH-1:0];
            end
            else if (cfg_index == REG_EXPONENT)
            begin
                exponent_next = cfg_data[EXP_WIDTH-1:0];
            end
        end

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (exponent_reg == '0)
                    begin
                        // zero exponent gives 1 with no reduction
                        acc_next   = MOD_WIDTH'(1);
                        state_next = S_DONE;
                    end
                    else if (modulus_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // reduction runs the multiplier with b = 1 over all base bits
                        mul_a_next = base;
                        mul_b_next = MOD_WIDTH'(1);
                        mul_r_next = '0;
                        cnt_next   = CNT_WIDTH'(BASE_WIDTH);
                        state_next = S_RED;
                    end
                end
            end

            S_RED:
            begin
                mul_a_next = {mul_a_reg[BASE_WIDTH-2:0], 1'b0};
                mul_r_next = step_r;
                cnt_next   = cnt_reg - CNT_WIDTH'(1);
                if (mul_last)
                begin
                    sq_next     = step_r;
                    acc_next    = MOD_WIDTH'(1);
                    exp_sh_next = exponent_reg;
                    state_next  = S_STEP;
                end
            end

            S_STEP:
            begin
                mul_r_next = '0;
                cnt_next   = CNT_WIDTH'(MOD_WIDTH);
                mul_b_next = sq_reg;
                if (exp_sh_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (exp_sh_reg[0])
                begin
                    mul_a_next = {acc_reg, {PAD_WIDTH{1'b0}}};
                    state_next = S_MUL;
                end
                else
                begin
                    mul_a_next = {sq_reg, {PAD_WIDTH{1'b0}}};
                    state_next = S_SQR;
                end
            end

            S_MUL:
            begin
                mul_a_next = {mul_a_reg[BASE_WIDTH-2:0], 1'b0};
                mul_r_next = step_r;
                cnt_next   = cnt_reg - CNT_WIDTH'(1);
                if (mul_last)
                begin
                    // product done, square follows on the same unit
                    acc_next   = step_r;
                    mul_a_next = {sq_reg, {PAD_WIDTH{1'b0}}};
                    mul_b_next = sq_reg;
                    mul_r_next = '0;
                    cnt_next   = CNT_WIDTH'(MOD_WIDTH);
                    state_next = S_SQR;
                end
            end

            S_SQR:
            begin
                mul_a_next = {mul_a_reg[BASE_WIDTH-2:0], 1'b0};
                mul_r_next = step_r;
                cnt_next   = cnt_reg - CNT_WIDTH'(1);
                if (mul_last)
                begin
                    sq_next     = step_r;
                    exp_sh_next = exp_sh_reg >> 1;
                    state_next  = S_STEP;
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    power_next     = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MOD_WIDTH'(1);
            exponent_reg  <= '0;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        mul_r_reg  <= mul_r_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_sh_reg <= exp_sh_next;
        power_reg  <= power_next;
    end

    // a new request can enter while the previous result still waits
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign power     = power_reg;

`ifndef NO_ASSERTIONS
    // an accepted request always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
    else $error("request accepted but controller stayed idle");

    // partial remainder stays reduced while the multiplier runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED || state_reg == S_MUL || state_reg == S_SQR)
        |-> (mul_r_reg < modulus_reg))
    else $error("serial multiplier remainder not below modulus");

    // running square is reduced between exponent bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (sq_reg < modulus_reg))
    else $error("running square not below modulus");

    // a finished result reaches the output register once it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid && state_reg == S_IDLE))
    else $error("finished result not handed to the output");
`endif

endmodule : modular_exponentiation
`default_nettype wire
